FILE: rtl/grmp_pkg.sv
// shared constants, codes and types of the group ring multiplier
package grmp_pkg;

	// default sizes
	localparam int MAX_ORDER_DEF  = 16;
	localparam int COEF_WIDTH_DEF = 8;

	// field widths of the stream words
	localparam int CMD_W        = 2;
	localparam int IDX_FIELD_W  = 4;
	localparam int ENT_W        = 4;
	localparam int COEF_FIELD_W = 8;

	// input word layout, lowest bit first
	localparam int ROW_LSB   = 0;
	localparam int COL_LSB   = ROW_LSB + IDX_FIELD_W;
	localparam int ENT_LSB   = COL_LSB + IDX_FIELD_W;
	localparam int X_LSB     = ENT_LSB + ENT_W;
	localparam int Y_LSB     = X_LSB + COEF_FIELD_W;
	localparam int S_TDATA_W = 32;

	// output word layout
	localparam int OIDX_LSB  = 0;
	localparam int OVAL_LSB  = OIDX_LSB + IDX_FIELD_W;
	localparam int OUSED_W   = OVAL_LSB + COEF_FIELD_W;
	localparam int M_TDATA_W = 16;

	// configuration registers
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;
	localparam int MOD_REG_W   = 8;
	localparam int ORDER_REG_W = 5;
	localparam logic [MOD_REG_W-1:0]   MODULUS_RST = 8'd2;
	localparam logic [ORDER_REG_W-1:0] ORDER_RST   = 5'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODULUS = 1'b0,
		REG_ORDER   = 1'b1
	} reg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_TBL  = 2'd0,
		CMD_COEF = 2'd1,
		CMD_MUL  = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_X,
		ST_LD_XW,
		ST_LD_Y,
		ST_LD_YW,
		ST_MAC,
		ST_FLUSH,
		ST_DR_RD,
		ST_DR_DATA,
		ST_DR_RED,
		ST_DR_OUT
	} state_t;

endpackage

FILE: rtl/grmp_ram.sv
// generic simple dual-port ram, one write port, one registered read port
module grmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read during write to the same entry returns the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/grmp_mod_unit.sv
// bit-serial remainder unit, one restoring step per cycle
module grmp_mod_unit #(
	parameter int COEF_WIDTH = 8,
	parameter int ACC_WIDTH  = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ACC_WIDTH-1:0]  value,
	input  logic [COEF_WIDTH:0]   modulus,
	output logic                  done,
	output logic [COEF_WIDTH-1:0] result
);

	localparam int P_W   = COEF_WIDTH + 1;
	localparam int CNT_W = $clog2(ACC_WIDTH + 1);

	logic [ACC_WIDTH-1:0] val_q;
	logic [P_W-1:0]       rem_q;
	logic [P_W-1:0]       rem_sh;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;

	// remainder stays below the modulus, so the top bit is free for the shift
	assign rem_sh = {rem_q[P_W-2:0], val_q[ACC_WIDTH-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(ACC_WIDTH);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			val_q <= val_q << 1;
			rem_q <= (rem_sh >= modulus) ? (rem_sh - modulus) : rem_sh;
		end
	end

	assign done   = done_q;
	assign result = rem_q[COEF_WIDTH-1:0];

endmodule

FILE: rtl/group_ring_multiply_mod_p.sv
// group ring multiplier over the integers modulo p, top level
//
// The block multiplies two elements of a group ring whose coefficients live
// in Z/p. Software loads the group's multiplication table one entry per input
// word (command 0, zero-based product index), then the coefficient pairs
// (command 1, reduced modulo p on load), then issues a multiply (command 2),
// which answers with n output words, one per product coefficient in index
// order, the last one marked with m_tlast. Set modulus and group_order on the
// cfg channel only while the block is idle; cfg_ready is always high. A
// modulus of zero means 2^COEF_WIDTH, a group order of zero means one, and
// an order above MAX_ORDER is clipped. Table entries at or above n are
// skipped during a multiply. Both values of a coefficient pair go through the
// bit-serial remainder unit one bit per cycle; it works on ACC_W bits, where
// ACC_W is 2*COEF_WIDTH+2*clog2(MAX_ORDER) (24 at the defaults). A multiply
// runs the multiply-accumulate loop, which reads one table entry per cycle
// from the table ram, then reduces and emits the accumulators through the
// same remainder unit; m_tready can hold off the output. The accumulators
// sum exact products without reduction and are brought into range once at
// the end. There is no clearing pass after reset: table and coefficient
// entries that were never written read back undefined data, while
// accumulators not yet written in a multiply read as zero.
module group_ring_multiply_mod_p #(
	parameter int MAX_ORDER  = grmp_pkg::MAX_ORDER_DEF,
	parameter int COEF_WIDTH = grmp_pkg::COEF_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [grmp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [grmp_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// row_index[3:0], col_index[7:4], table_entry[11:8], x_coef[19:12],
	// y_coef[27:20], zero fill above
	input  logic [grmp_pkg::S_TDATA_W-1:0]   s_tdata,
	// cmd[1:0]
	input  logic [grmp_pkg::CMD_W-1:0]       s_tuser,
	// output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// coef_index[3:0], coef_value[11:4], zero fill above
	output logic [grmp_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                             m_tlast
);

	localparam int IDX_W     = $clog2(MAX_ORDER);
	localparam int N_W       = $clog2(MAX_ORDER + 1);
	localparam int TBL_DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int TA_W      = $clog2(TBL_DEPTH);
	localparam int CW        = COEF_WIDTH;
	localparam int P_W       = CW + 1;
	// exact sum of up to n*n products of two coefficients
	localparam int ACC_W     = 2 * CW + 2 * IDX_W;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [grmp_pkg::MOD_REG_W-1:0]   modulus_q;
	logic [grmp_pkg::ORDER_REG_W-1:0] order_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= grmp_pkg::MODULUS_RST;
			order_q   <= grmp_pkg::ORDER_RST;
		end else if (cfg_valid) begin
			unique case (grmp_pkg::reg_idx_t'(cfg_index))
				grmp_pkg::REG_MODULUS: begin
					modulus_q <= cfg_data[grmp_pkg::MOD_REG_W-1:0];
				end
				grmp_pkg::REG_ORDER: begin
					order_q <= cfg_data[grmp_pkg::ORDER_REG_W-1:0];
				end
			endcase
		end
	end

	// effective modulus: zero stands for 2^CW
	logic [CW-1:0]  p_low;
	logic [P_W-1:0] p_eff;

	assign p_low = CW'(modulus_q);
	assign p_eff = (p_low == '0) ? {1'b1, {CW{1'b0}}} : {1'b0, p_low};

	// effective group order n, clipped to 1..MAX_ORDER
	logic [N_W-1:0] n_eff;
	logic [N_W-1:0] n_m1;

	always_comb begin
		if (order_q == '0) begin
			n_eff = N_W'(1);
		end else if (32'(order_q) > 32'(MAX_ORDER)) begin
			n_eff = N_W'(MAX_ORDER);
		end else begin
			n_eff = N_W'(order_q);
		end
	end

	assign n_m1 = n_eff - N_W'(1);

	// ------------------------------------------------------------------
	// input word fields
	// ------------------------------------------------------------------
	logic [grmp_pkg::CMD_W-1:0]        in_cmd;
	logic [grmp_pkg::IDX_FIELD_W-1:0]  in_row;
	logic [grmp_pkg::IDX_FIELD_W-1:0]  in_col;
	logic [grmp_pkg::ENT_W-1:0]        in_ent;
	logic [grmp_pkg::COEF_FIELD_W-1:0] in_x;
	logic [grmp_pkg::COEF_FIELD_W-1:0] in_y;
	logic                              accept;
	logic                              row_ok;
	logic                              col_ok;
	logic                              mul_start;

	assign in_cmd = s_tuser;
	assign in_row = s_tdata[grmp_pkg::ROW_LSB +: grmp_pkg::IDX_FIELD_W];
	assign in_col = s_tdata[grmp_pkg::COL_LSB +: grmp_pkg::IDX_FIELD_W];
	assign in_ent = s_tdata[grmp_pkg::ENT_LSB +: grmp_pkg::ENT_W];
	assign in_x   = s_tdata[grmp_pkg::X_LSB +: grmp_pkg::COEF_FIELD_W];
	assign in_y   = s_tdata[grmp_pkg::Y_LSB +: grmp_pkg::COEF_FIELD_W];

	assign accept    = s_tvalid && s_tready;
	assign row_ok    = (32'(in_row) < 32'(MAX_ORDER));
	assign col_ok    = (32'(in_col) < 32'(MAX_ORDER));
	assign mul_start = accept && (in_cmd == grmp_pkg::CMD_MUL);

	// ------------------------------------------------------------------
	// state and loop counters
	// ------------------------------------------------------------------
	grmp_pkg::state_t state_q;
	grmp_pkg::state_t state_d;

	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	logic [TA_W-1:0]  row_base_q;
	logic             i_last;
	logic             j_last;
	logic             k_last;

	assign i_last = (N_W'(i_q) == n_m1);
	assign j_last = (N_W'(j_q) == n_m1);
	assign k_last = (N_W'(k_q) == n_m1);

	// pipeline flags of the multiply-accumulate loop
	logic vld_s1;
	logic wr_s2;

	// remainder unit
	logic             u_start;
	logic [ACC_W-1:0] u_value;
	logic             u_done;
	logic [CW-1:0]    u_result;

	// fsm outputs
	logic issue;
	logic x_we;
	logic y_we;
	logic dr_load;

	// output register
	logic                              m_tvalid_q;
	logic [grmp_pkg::IDX_FIELD_W-1:0]  m_idx_q;
	logic [grmp_pkg::COEF_FIELD_W-1:0] m_val_q;
	logic                              m_last_q;

	// latched coefficient write
	logic [grmp_pkg::COEF_FIELD_W-1:0] ld_x_q;
	logic [grmp_pkg::COEF_FIELD_W-1:0] ld_y_q;
	logic [IDX_W-1:0]                  ld_row_q;

	// accumulator value seen by the drain
	logic [ACC_W-1:0] acc_rd;
	logic [ACC_W-1:0] acc_dr_val;
	logic [MAX_ORDER-1:0] acc_vld_q;

	assign acc_dr_val = acc_vld_q[k_q] ? acc_rd : '0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			grmp_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_cmd)
						grmp_pkg::CMD_COEF: begin
							if (row_ok) begin
								state_d = grmp_pkg::ST_LD_X;
							end
						end
						grmp_pkg::CMD_MUL: begin
							state_d = grmp_pkg::ST_MAC;
						end
						default: begin
							state_d = grmp_pkg::ST_IDLE;
						end
					endcase
				end
			end
			grmp_pkg::ST_LD_X: begin
				state_d = grmp_pkg::ST_LD_XW;
			end
			grmp_pkg::ST_LD_XW: begin
				if (u_done) begin
					state_d = grmp_pkg::ST_LD_Y;
				end
			end
			grmp_pkg::ST_LD_Y: begin
				state_d = grmp_pkg::ST_LD_YW;
			end
			grmp_pkg::ST_LD_YW: begin
				if (u_done) begin
					state_d = grmp_pkg::ST_IDLE;
				end
			end
			grmp_pkg::ST_MAC: begin
				if (i_last && j_last) begin
					state_d = grmp_pkg::ST_FLUSH;
				end
			end
			grmp_pkg::ST_FLUSH: begin
				// wait until the last accumulator write has landed
				if (!vld_s1 && !wr_s2) begin
					state_d = grmp_pkg::ST_DR_RD;
				end
			end
			grmp_pkg::ST_DR_RD: begin
				state_d = grmp_pkg::ST_DR_DATA;
			end
			grmp_pkg::ST_DR_DATA: begin
				state_d = grmp_pkg::ST_DR_RED;
			end
			grmp_pkg::ST_DR_RED: begin
				if (u_done) begin
					state_d = grmp_pkg::ST_DR_OUT;
				end
			end
			grmp_pkg::ST_DR_OUT: begin
				if (dr_load) begin
					state_d = k_last ? grmp_pkg::ST_IDLE : grmp_pkg::ST_DR_RD;
				end
			end
			default: begin
				state_d = grmp_pkg::ST_IDLE;
			end
		endcase
	end

	// fsm outputs
	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		u_start  = 1'b0;
		u_value  = '0;
		x_we     = 1'b0;
		y_we     = 1'b0;
		dr_load  = 1'b0;
		unique case (state_q)
			grmp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			grmp_pkg::ST_LD_X: begin
				u_start = 1'b1;
				u_value = ACC_W'(ld_x_q);
			end
			grmp_pkg::ST_LD_XW: begin
				x_we = u_done;
			end
			grmp_pkg::ST_LD_Y: begin
				u_start = 1'b1;
				u_value = ACC_W'(ld_y_q);
			end
			grmp_pkg::ST_LD_YW: begin
				y_we = u_done;
			end
			grmp_pkg::ST_MAC: begin
				issue = 1'b1;
			end
			grmp_pkg::ST_DR_DATA: begin
				u_start = 1'b1;
				u_value = acc_dr_val;
			end
			grmp_pkg::ST_DR_OUT: begin
				// next word goes in when the output register is free
				dr_load = !m_tvalid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grmp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			row_base_q <= '0;
		end else begin
			if (mul_start) begin
				i_q        <= '0;
				j_q        <= '0;
				k_q        <= '0;
				row_base_q <= '0;
			end else begin
				if (issue) begin
					if (j_last) begin
						j_q        <= '0;
						i_q        <= i_q + IDX_W'(1);
						row_base_q <= row_base_q + TA_W'(MAX_ORDER);
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				if (dr_load && !k_last) begin
					k_q <= k_q + IDX_W'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// memories
	// ------------------------------------------------------------------
	logic                       tbl_we;
	logic [TA_W-1:0]            tbl_waddr;
	logic [TA_W-1:0]            tbl_raddr;
	logic [grmp_pkg::ENT_W-1:0] tbl_rd;
	logic [CW-1:0]              x_rd;
	logic [CW-1:0]              y_rd;

	assign tbl_we    = accept && (in_cmd == grmp_pkg::CMD_TBL) && row_ok && col_ok;
	assign tbl_waddr = TA_W'(in_row) * TA_W'(MAX_ORDER) + TA_W'(in_col);
	assign tbl_raddr = row_base_q + TA_W'(j_q);

	grmp_ram #(
		.WIDTH (grmp_pkg::ENT_W),
		.DEPTH (TBL_DEPTH)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (in_ent),
		.raddr (tbl_raddr),
		.rdata (tbl_rd)
	);

	grmp_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_ORDER)
	) u_x_ram (
		.clk   (clk),
		.we    (x_we),
		.waddr (ld_row_q),
		.wdata (u_result),
		.raddr (i_q),
		.rdata (x_rd)
	);

	grmp_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_ORDER)
	) u_y_ram (
		.clk   (clk),
		.we    (y_we),
		.waddr (ld_row_q),
		.wdata (u_result),
		.raddr (j_q),
		.rdata (y_rd)
	);

	// ------------------------------------------------------------------
	// multiply-accumulate pipeline
	// s0 issue table/x/y reads, s1 multiply and read accumulator,
	// s2 add and write back
	// ------------------------------------------------------------------
	logic [IDX_W-1:0]  t_s1;
	logic              keep_s1;
	logic [2*CW-1:0]   prod_s2;
	logic [IDX_W-1:0]  t_s2;
	logic [IDX_W-1:0]  acc_raddr;
	logic [ACC_W-1:0]  acc_old;
	logic [ACC_W-1:0]  acc_sum;
	logic              fwd_vld_q;
	logic [IDX_W-1:0]  fwd_idx_q;
	logic [ACC_W-1:0]  fwd_sum_q;

	assign t_s1    = IDX_W'(tbl_rd);
	// terms whose product index is not below n are dropped
	assign keep_s1 = vld_s1 && (32'(tbl_rd) < 32'(n_eff));

	assign acc_raddr = (state_q == grmp_pkg::ST_DR_RD) ? k_q : t_s1;

	// a write that lands at the same edge as the ram read is not yet visible in the read data
	always_comb begin
		if (fwd_vld_q && (fwd_idx_q == t_s2)) begin
			acc_old = fwd_sum_q;
		end else if (acc_vld_q[t_s2]) begin
			acc_old = acc_rd;
		end else begin
			acc_old = '0;
		end
	end

	assign acc_sum = acc_old + ACC_W'(prod_s2);

	grmp_ram #(
		.WIDTH (ACC_W),
		.DEPTH (MAX_ORDER)
	) u_acc_ram (
		.clk   (clk),
		.we    (wr_s2),
		.waddr (t_s2),
		.wdata (acc_sum),
		.raddr (acc_raddr),
		.rdata (acc_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			wr_s2     <= 1'b0;
			fwd_vld_q <= 1'b0;
			acc_vld_q <= '0;
		end else begin
			vld_s1    <= issue;
			wr_s2     <= keep_s1;
			fwd_vld_q <= wr_s2;
			// accumulators read as zero until written in this multiply
			if (mul_start) begin
				acc_vld_q <= '0;
			end else if (wr_s2) begin
				acc_vld_q[t_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2   <= x_rd * y_rd;
		t_s2      <= t_s1;
		fwd_idx_q <= t_s2;
		fwd_sum_q <= acc_sum;
	end

	// ------------------------------------------------------------------
	// remainder unit, shared by coefficient loads and the drain
	// ------------------------------------------------------------------
	grmp_mod_unit #(
		.COEF_WIDTH (CW),
		.ACC_WIDTH  (ACC_W)
	) u_mod_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (u_start),
		.value   (u_value),
		.modulus (p_eff),
		.done    (u_done),
		.result  (u_result)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			ld_x_q   <= in_x;
			ld_y_q   <= in_y;
			ld_row_q <= IDX_W'(in_row);
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (dr_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dr_load) begin
			m_idx_q  <= grmp_pkg::IDX_FIELD_W'(k_q);
			m_val_q  <= grmp_pkg::COEF_FIELD_W'(u_result);
			m_last_q <= k_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {{(grmp_pkg::M_TDATA_W - grmp_pkg::OUSED_W){1'b0}}, m_val_q, m_idx_q};

endmodule

FILE: rtl/grmp_checker.sv
// port-level checks of the group ring multiplier and their bind
module grmp_port_checks (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [grmp_pkg::CMD_W-1:0]     s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [grmp_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tlast
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	else $error("output word changed while stalled");

	// a multiply blocks the input on the next cycle
	a_mul_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == grmp_pkg::CMD_MUL) |=> !s_tready)
	else $error("input taken right after a multiply command");

	// new output words only come out of the drain, with the input closed
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
	else $error("output word appeared while input was open");

	// a waiting word that is not the last of its product keeps the input closed
	a_mid_prod: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
	else $error("input opened in the middle of a product");

endmodule

bind group_ring_multiply_mod_p grmp_port_checks u_grmp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

FILE: tb/grmp_checker.sv
// checker for the group ring multiplier: tracks its state, predicts the output words and compares them
module grmp_checker
	import grmp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic [CMD_W-1:0]      s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  m_tlast,
	output int                    pending,
	output int                    mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [IDX_FIELD_W-1:0]  index;
		logic [COEF_FIELD_W-1:0] value;
		logic                    last;
	} coef_word_t;

	coef_word_t coef_due [$];

	logic [MOD_REG_W-1:0]   modulus_reg = MODULUS_RST;
	logic [ORDER_REG_W-1:0] order_reg   = ORDER_RST;
	logic [ENT_W-1:0]       cayley [MAX_ORDER_DEF][MAX_ORDER_DEF];
	int unsigned            x_held [MAX_ORDER_DEF];
	int unsigned            y_held [MAX_ORDER_DEF];
	int                     errors = 0;

	// zero means plain wrap at the coefficient width
	function automatic int unsigned ring_modulus();
		if (modulus_reg == '0)
			return 1 << COEF_WIDTH_DEF;
		return modulus_reg;
	endfunction

	function automatic int unsigned elem_count();
		if (order_reg == '0)
			return 1;
		if (order_reg > MAX_ORDER_DEF)
			return MAX_ORDER_DEF;
		return order_reg;
	endfunction

	task automatic note_mismatch(input string field, input logic [15:0] want, input logic [15:0] got);
		errors++;
		if (errors <= 10)
			$display("mismatch on %s: expected %0d, got %0d", field, want, got);
	endtask

	// product of the two stored elements, one word per coefficient
	task automatic predict_product();
		int unsigned n, p, t, i, j;
		int unsigned acc [MAX_ORDER_DEF];
		coef_word_t w;
		n = elem_count();
		p = ring_modulus();
		foreach (acc[k])
			acc[k] = 0;
		for (i = 0; i < n; i++) begin
			for (j = 0; j < n; j++) begin
				t = cayley[i][j];
				// products landing outside the group in use are dropped
				if (t < n)
					acc[t] = (acc[t] + x_held[i] * y_held[j]) % p;
			end
		end
		for (i = 0; i < n; i++) begin
			w.index = i[IDX_FIELD_W-1:0];
			w.value = acc[i][COEF_FIELD_W-1:0];
			w.last  = (i + 1 == n);
			coef_due.push_back(w);
		end
	endtask

	task automatic take_item();
		logic [IDX_FIELD_W-1:0]  row, col;
		logic [ENT_W-1:0]        ent;
		logic [COEF_FIELD_W-1:0] xc, yc;
		row = s_tdata[ROW_LSB +: IDX_FIELD_W];
		col = s_tdata[COL_LSB +: IDX_FIELD_W];
		ent = s_tdata[ENT_LSB +: ENT_W];
		xc  = s_tdata[X_LSB +: COEF_FIELD_W];
		yc  = s_tdata[Y_LSB +: COEF_FIELD_W];
		case (s_tuser)
			CMD_TBL: begin
				cayley[row][col] = ent;
			end
			CMD_COEF: begin
				x_held[row] = xc % ring_modulus();
				y_held[row] = yc % ring_modulus();
			end
			CMD_MUL: begin
				predict_product();
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_word();
		coef_word_t want;
		logic [IDX_FIELD_W-1:0]  got_idx;
		logic [COEF_FIELD_W-1:0] got_val;
		got_idx = m_tdata[OIDX_LSB +: IDX_FIELD_W];
		got_val = m_tdata[OVAL_LSB +: COEF_FIELD_W];
		if (coef_due.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected word: index %0d value %0d last %0b", got_idx, got_val, m_tlast);
			return;
		end
		want = coef_due.pop_front();
		if (got_idx !== want.index)
			note_mismatch("coef_index", want.index, got_idx);
		if (got_val !== want.value)
			note_mismatch("coef_value", want.value, got_val);
		if (m_tlast !== want.last)
			note_mismatch("last", want.last, m_tlast);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_reg = MODULUS_RST;
			order_reg   = ORDER_RST;
			coef_due.delete();
			pending    <= 0;
			mismatches <= 0;
		end else begin
			// output side first, a multiply taken at this edge cannot answer at it
			if (m_tvalid && m_tready)
				check_word();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODULUS: modulus_reg = cfg_data[MOD_REG_W-1:0];
					REG_ORDER:   order_reg   = cfg_data[ORDER_REG_W-1:0];
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready)
				take_item();
			pending    <= coef_due.size();
			mismatches <= errors;
		end
	end

endmodule

FILE: tb/testbench.sv
// top of the group ring multiplier bench: clock, reset, stimulus and verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import grmp_pkg::*;

	// command code the block ignores
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	// a coefficient pair is still being reduced after it is taken, leave room after the last one
	localparam int SETTLE_CYCLES = 80;
	localparam int END_CYCLES    = 100;
	localparam int RANDOM_ITEMS  = 320;
	localparam int MIN_WORDS     = 48;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_MODULUS;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic [CMD_W-1:0]      s_tuser   = CMD_TBL;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tlast;
	int                    pending;
	int                    mismatches;

	// gap style per side: 0 means back to back, 1 means random gaps
	int tx_mode = 0;
	int rx_mode = 0;
	int rx_hold;

	// group order in effect, as the last order write leaves it
	int order_now = 16;

	// counters that decide when the random part stops
	int items_done = 0;
	int words_total = 0;

	// which store entries hold written data, so nothing unwritten is read
	bit tbl_loaded [16][16];
	bit coef_loaded [16];

	group_ring_multiply_mod_p uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	grmp_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.pending    (pending),
		.mismatches (mismatches)
	);

	always #1 clk = ~clk;

	// gap length in cycles: mostly none or short, now and then long
	function automatic int gap_len(input int mode);
		int r;
		if (mode == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// coefficient with extra weight on the extremes
	function automatic int pick_coef();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// modulus value, zero and one included
	function automatic logic [7:0] pick_modulus();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd2;
			3: return 8'd255;
			4: return 8'd3;
			default: return 8'($urandom_range(2, 255));
		endcase
	endfunction

	// order register value for n, upper data bits random; zero stands for one and
	// anything above the maximum for the maximum
	function automatic logic [7:0] order_code(input int n);
		logic [2:0] hi;
		logic [4:0] lo;
		hi = 3'($urandom_range(0, 7));
		lo = 5'(n);
		if (n == 1 && $urandom_range(0, 1) == 1)
			lo = 5'd0;
		if (n == 16 && $urandom_range(0, 1) == 1)
			lo = 5'($urandom_range(17, 31));
		return {hi, lo};
	endfunction

	// receiver: ready most cycles, with stalls of random length between in random-gap mode
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold = 0;
		end else if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				rx_hold = gap_len(rx_mode);
		end
	end

	// one input word; valid stays high into the next word unless a gap comes
	task automatic send_word(input logic [CMD_W-1:0] c, input int row, input int col,
			input int ent, input int xv, input int yv);
		int gap;
		logic [S_TDATA_W-1:0] word;
		gap = gap_len(tx_mode);
		word = '0;
		word[ROW_LSB +: IDX_FIELD_W] = IDX_FIELD_W'(row);
		word[COL_LSB +: IDX_FIELD_W] = IDX_FIELD_W'(col);
		word[ENT_LSB +: ENT_W]       = ENT_W'(ent);
		word[X_LSB +: COEF_FIELD_W]  = COEF_FIELD_W'(xv);
		word[Y_LSB +: COEF_FIELD_W]  = COEF_FIELD_W'(yv);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (c == CMD_TBL)
			tbl_loaded[row][col] = 1'b1;
		if (c == CMD_COEF)
			coef_loaded[row] = 1'b1;
		if (c != CMD_NONE)
			items_done++;
	endtask

	// register write, only while the block is idle
	task automatic set_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_ORDER) begin
			if (val[4:0] == 5'd0)
				order_now = 1;
			else if (val[4:0] > 5'd16)
				order_now = 16;
			else
				order_now = int'(val[4:0]);
		end
	endtask

	// hold the input until every expected word has come, then wait settle cycles
	task automatic quiesce(input int settle);
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (settle) @(posedge clk);
	endtask

	// multiply command; any table entry or coefficient in use that was never
	// written gets a value first
	task automatic multiply();
		int i, j;
		for (i = 0; i < order_now; i++) begin
			if (!coef_loaded[i])
				send_word(CMD_COEF, i, $urandom_range(0, 15), $urandom_range(0, 15),
					pick_coef(), pick_coef());
			for (j = 0; j < order_now; j++) begin
				if (!tbl_loaded[i][j])
					send_word(CMD_TBL, i, j, $urandom_range(0, order_now - 1),
						$urandom_range(0, 255), $urandom_range(0, 255));
			end
		end
		send_word(CMD_MUL, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
			$urandom_range(0, 255), $urandom_range(0, 255));
		words_total += order_now;
	endtask

	// one random phase: settings, table, operands, a few products
	task automatic run_session();
		int n, r, style, reps, k, i, j;
		int ent;
		r = $urandom_range(0, 99);
		if (r < 75)
			n = $urandom_range(1, 4);
		else if (r < 92)
			n = $urandom_range(5, 8);
		else
			n = $urandom_range(9, 16);

		quiesce(SETTLE_CYCLES);
		set_reg(REG_MODULUS, pick_modulus());
		set_reg(REG_ORDER, order_code(n));
		tx_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
		rx_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;

		// big tables are reloaded only now and then, they cost n*n words
		style = $urandom_range(0, 3);
		if ((n <= 8) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0)) begin
			for (i = 0; i < n; i++) begin
				for (j = 0; j < n; j++) begin
					case (style)
						0: ent = (i + j) % n;               // cyclic group
						1: ent = i ^ j;                     // elementary abelian when n is a power of two
						2: ent = $urandom_range(0, n - 1);
						default: ent = $urandom_range(0, 15); // may fall outside the group
					endcase
					send_word(CMD_TBL, i, j, ent, $urandom_range(0, 255), $urandom_range(0, 255));
				end
			end
		end else begin
			repeat ($urandom_range(1, 4))
				send_word(CMD_TBL, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
					$urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 255));
		end

		for (i = 0; i < n; i++)
			send_word(CMD_COEF, i, $urandom_range(0, 15), $urandom_range(0, 15),
				pick_coef(), pick_coef());

		reps = $urandom_range(1, 3);
		repeat (reps) begin
			// noise between products: ignored words and stray rewrites
			k = $urandom_range(0, 3);
			repeat (k) begin
				case ($urandom_range(0, 2))
					0: send_word(CMD_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
						$urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 255));
					1: send_word(CMD_TBL, $urandom_range(0, 15), $urandom_range(0, 15),
						$urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 255));
					default: send_word(CMD_COEF, $urandom_range(0, 15), $urandom_range(0, 15),
						$urandom_range(0, 15), pick_coef(), pick_coef());
				endcase
			end
			multiply();
			// now and then the sender holds until the whole product is out
			if ($urandom_range(0, 3) == 0)
				quiesce(0);
		end

		// shrink the modulus under operands loaded with a larger one
		if ($urandom_range(0, 4) == 0) begin
			quiesce(SETTLE_CYCLES);
			set_reg(REG_MODULUS, 8'($urandom_range(2, 40)));
			multiply();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no gaps
		tx_mode = 0;
		rx_mode = 0;
		set_reg(REG_MODULUS, 8'd255);
		set_reg(REG_ORDER, 8'd2);
		// cyclic group of order two
		send_word(CMD_TBL, 0, 0, 0, 0, 0);
		send_word(CMD_TBL, 0, 1, 1, 255, 255);
		send_word(CMD_TBL, 1, 0, 1, 0, 255);
		send_word(CMD_TBL, 1, 1, 0, 255, 0);
		// 255 reduces to zero on load
		send_word(CMD_COEF, 0, 0, 0, 255, 255);
		send_word(CMD_COEF, 1, 0, 0, 254, 1);
		multiply();
		// ignored command with every field at its top
		send_word(CMD_NONE, 15, 15, 15, 255, 255);

		// modulus zero wraps at 256
		quiesce(SETTLE_CYCLES);
		set_reg(REG_MODULUS, 8'd0);
		send_word(CMD_COEF, 0, 15, 15, 255, 255);
		send_word(CMD_COEF, 1, 15, 15, 255, 128);
		multiply();

		// operands above a modulus set after loading are used as stored
		quiesce(SETTLE_CYCLES);
		set_reg(REG_MODULUS, 8'd7);
		multiply();

		// top indexes, and a table entry outside the group in use
		send_word(CMD_TBL, 15, 15, 15, 0, 0);
		send_word(CMD_COEF, 15, 0, 0, 0, 255);
		send_word(CMD_TBL, 0, 1, 15, 0, 0);
		multiply();

		// order zero acts as one
		quiesce(SETTLE_CYCLES);
		set_reg(REG_ORDER, 8'd0);
		multiply();

		// modulus one, order with upper data bits set
		quiesce(SETTLE_CYCLES);
		set_reg(REG_MODULUS, 8'd1);
		set_reg(REG_ORDER, 8'h22);
		multiply();
		send_word(CMD_COEF, 1, 0, 0, 200, 77);
		multiply();

		// random part
		items_done = 0;
		words_total = 0;
		while (items_done < RANDOM_ITEMS || words_total < MIN_WORDS)
			run_session();

		quiesce(END_CYCLES);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog, several times a run in which every word is a full-order multiply
	// drained under the longest stalls
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
